### src/mbet_pkg.sv
package mbet_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_X_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_MAX    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd6;

  // Register and datapath widths
  localparam int Q_W       = 32;  // signed Q4.28 coordinate
  localparam int DIM_W     = 13;  // image width / height
  localparam int ITER_W    = 17;  // iteration cap register
  localparam int SPAN_W    = 33;  // exact span of two Q4.28 values
  localparam int MUL_A_W   = 33;
  localparam int MUL_B_W   = 32;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = 64;  // squares and cross product in Q.56
  localparam int Z_W       = 34;  // z components in Q.28 after one step
  localparam int FRAC_BITS = 28;

  // Reset values of the registers
  localparam logic signed [Q_W-1:0] X_MIN_RST    = -32'sd536870912;
  localparam logic signed [Q_W-1:0] X_MAX_RST    = 32'sd536870912;
  localparam logic signed [Q_W-1:0] Y_MIN_RST    = -32'sd536870912;
  localparam logic signed [Q_W-1:0] Y_MAX_RST    = 32'sd536870912;
  localparam logic [DIM_W-1:0]      WIDTH_RST    = 13'd800;
  localparam logic [DIM_W-1:0]      HEIGHT_RST   = 13'd800;
  localparam logic [ITER_W-1:0]     MAX_ITER_RST = 17'd100000;

  // Thresholds
  localparam logic [ACC_W:0] DISK_LIM = (ACC_W+1)'(1) << (2 * FRAC_BITS - 4); // 1/16 in Q.56
  localparam logic [ACC_W:0] ESC_LIM  = (ACC_W+1)'(1) << (2 * FRAC_BITS + 2); // 4 in Q.56
  localparam logic [Z_W-1:0] TWO_Q    = Z_W'(1) << (FRAC_BITS + 1);           // 2 in Q.28

endpackage

### src/mandelbrot_escape_time.sv
// Each pixel maps both axes through the divider, then takes n z steps (at most
//   max_iterations); pixels inside the small disk skip the steps entirely.
// Throughput: one pixel at a time; the 1-bit-per-cycle mapping divider and the shared
//   multiplier (three products per step) set the figure. A count that finds the result
//   word still waiting holds the sequencer, and so the input, until that word is taken.
// Reset: synchronous, active high; registers return to -2..2 region, 800x800, cap 100000.
module mandelbrot_escape_time #(
  parameter int INDEX_BITS = 12,
  parameter int COUNT_BITS = 17
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [INDEX_BITS-1:0]           column,
  input  logic [INDEX_BITS-1:0]           row,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [COUNT_BITS-1:0]           iteration_count,
  input  logic                            cfg_write,
  input  logic [mbet_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbet_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mbet_pkg::*;

  // Dividend of the mapping divider: |span| * index, exact
  localparam int DVD_W  = SPAN_W + INDEX_BITS;
  localparam int DCNT_W = $clog2(DVD_W + 1);
  localparam int MAP_W  = DVD_W + 2;

  // Sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;   // |span| * index
  localparam logic [3:0] S_DIV  = 4'd2;   // restoring divide, one bit a cycle
  localparam logic [3:0] S_MAP  = 4'd3;   // add edge, saturate
  localparam logic [3:0] S_SQR  = 4'd4;   // c_re^2
  localparam logic [3:0] S_SQI  = 4'd5;   // c_im^2
  localparam logic [3:0] S_DISK = 4'd6;   // small-disk test
  localparam logic [3:0] S_IRR  = 4'd7;   // large-z test, re^2
  localparam logic [3:0] S_IRI  = 4'd8;   // re*im
  localparam logic [3:0] S_IIM  = 4'd9;   // im^2
  localparam logic [3:0] S_ESC  = 4'd10;  // |z|^2 test, cap test, step
  localparam logic [3:0] S_DONE = 4'd11;  // hand the count to the output register

  // Configuration registers
  logic signed [Q_W-1:0] x_min, x_max, y_min, y_max;
  logic [DIM_W-1:0]      image_width, image_height;
  logic [ITER_W-1:0]     max_iterations;

  // Sequencer and datapath registers
  logic [3:0]             state;
  logic                   axis;   // low while mapping the real part
  logic [INDEX_BITS-1:0]  idx_x, idx_y;
  logic signed [Q_W-1:0]  c_re, c_im;
  logic [PROD_W-1:0]      prod;
  logic [DIM_W-1:0]       rem;
  logic [DCNT_W-1:0]      dcnt;
  logic [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0] xprod;
  logic signed [Z_W-1:0]  re, im;
  logic [COUNT_BITS-1:0]  count;

  // Combinational
  logic signed [SPAN_W-1:0] span;
  logic [SPAN_W-1:0]        span_mag;
  logic                     span_neg;
  logic [INDEX_BITS-1:0]    idx;
  logic [DIM_W-1:0]         divisor;
  logic [DIM_W:0]           rem_shift;
  logic [DIM_W+1:0]         trial;
  logic                     borrow;
  logic signed [Q_W-1:0]    lo;
  logic signed [MAP_W-1:0]  lo_ext, q_ext, map_sum;
  logic                     map_fits;
  logic signed [Q_W-1:0]    sat_c;
  logic [Q_W-1:0]           c_re_mag, c_im_mag;
  logic [Z_W-1:0]           re_mag, im_mag;
  logic                     big;
  logic [MUL_A_W-1:0]       mul_a;
  logic [MUL_B_W-1:0]       mul_b;
  logic [PROD_W-1:0]        mul_p;
  logic [ACC_W:0]           sq_sum;
  logic signed [ACC_W-1:0]  sq, sq_sh, cross_sh;
  logic signed [Z_W-1:0]    re_next, im_next;
  logic [COUNT_BITS-1:0]    cap;

  assign in_ready = (state == S_IDLE);
  assign cap      = COUNT_BITS'(max_iterations);

  // Configuration writes; no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      x_min          <= X_MIN_RST;
      x_max          <= X_MAX_RST;
      y_min          <= Y_MIN_RST;
      y_max          <= Y_MAX_RST;
      image_width    <= WIDTH_RST;
      image_height   <= HEIGHT_RST;
      max_iterations <= MAX_ITER_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_X_MIN:    x_min          <= cfg_data;
        REG_X_MAX:    x_max          <= cfg_data;
        REG_Y_MIN:    y_min          <= cfg_data;
        REG_Y_MAX:    y_max          <= cfg_data;
        REG_WIDTH:    image_width    <= cfg_data[DIM_W-1:0];
        REG_HEIGHT:   image_height   <= cfg_data[DIM_W-1:0];
        REG_MAX_ITER: max_iterations <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // Mapping: span, divisor and edge of the axis in hand
  always_comb begin
    span     = axis ? (SPAN_W'(y_max) - SPAN_W'(y_min)) : (SPAN_W'(x_max) - SPAN_W'(x_min));
    span_neg = span[SPAN_W-1];
    span_mag = span_neg ? SPAN_W'(-span) : SPAN_W'(span);
    idx      = axis ? idx_y : idx_x;
    divisor  = axis ? image_height : image_width;
    if (divisor == '0) begin
      divisor = DIM_W'(1);   // a zero divisor counts as one
    end
    lo       = axis ? y_min : x_min;

    rem_shift = {rem, prod[DVD_W-1]};
    trial     = {1'b0, rem_shift} - {2'b00, divisor};
    borrow    = trial[DIM_W+1];

    // Quotient magnitude sits in the low bits of prod; apply the span's sign
    lo_ext   = MAP_W'(lo);
    q_ext    = $signed({2'b00, prod[DVD_W-1:0]});
    map_sum  = span_neg ? (lo_ext - q_ext) : (lo_ext + q_ext);
    map_fits = (map_sum[MAP_W-1:Q_W-1] == '0) || (map_sum[MAP_W-1:Q_W-1] == '1);
    if (map_fits) begin
      sat_c = map_sum[Q_W-1:0];
    end else begin
      sat_c = map_sum[MAP_W-1] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
    end
  end

  // Magnitudes feeding the shared multiplier
  always_comb begin
    c_re_mag = c_re[Q_W-1] ? Q_W'(-c_re) : Q_W'(c_re);
    c_im_mag = c_im[Q_W-1] ? Q_W'(-c_im) : Q_W'(c_im);
    re_mag   = re[Z_W-1] ? Z_W'(-re) : Z_W'(re);
    im_mag   = im[Z_W-1] ? Z_W'(-im) : Z_W'(im);
    big      = (re_mag >= TWO_Q) || (im_mag >= TWO_Q);
  end

  // Shared multiplier: operands picked by the sequencer, product registered in prod
  always_comb begin
    unique case (state)
      S_MUL: begin
        mul_a = span_mag;
        mul_b = MUL_B_W'(idx);
      end
      S_SQR: begin
        mul_a = MUL_A_W'(c_re_mag);
        mul_b = c_re_mag;
      end
      S_SQI: begin
        mul_a = MUL_A_W'(c_im_mag);
        mul_b = c_im_mag;
      end
      S_IRR: begin
        mul_a = MUL_A_W'(re_mag);
        mul_b = MUL_B_W'(re_mag);
      end
      S_IRI: begin
        mul_a = MUL_A_W'(re_mag);
        mul_b = MUL_B_W'(im_mag);
      end
      S_IIM: begin
        mul_a = MUL_A_W'(im_mag);
        mul_b = MUL_B_W'(im_mag);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Sum of squares for both the disk and the escape test; one z step
  always_comb begin
    sq_sum   = {1'b0, acc} + {1'b0, prod[ACC_W-1:0]};
    sq       = $signed(acc) - $signed(prod[ACC_W-1:0]);
    sq_sh    = sq >>> FRAC_BITS;                // floor toward minus infinity
    cross_sh = xprod >>> (FRAC_BITS - 1);       // 2*re*im
    re_next  = Z_W'(sq_sh) + Z_W'(c_re);
    im_next  = Z_W'(cross_sh) + Z_W'(c_im);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (dcnt == DCNT_W'(DVD_W - 1)) begin
            state <= S_MAP;
          end
        end
        S_MAP: begin
          state <= axis ? S_SQR : S_MUL;
        end
        S_SQR: begin
          state <= S_SQI;
        end
        S_SQI: begin
          state <= S_DISK;
        end
        S_DISK: begin
          state <= (sq_sum <= DISK_LIM) ? S_DONE : S_IRR;
        end
        S_IRR: begin
          state <= big ? S_DONE : S_IRI;
        end
        S_IRI: begin
          state <= S_IIM;
        end
        S_IIM: begin
          state <= S_ESC;
        end
        S_ESC: begin
          state <= ((sq_sum >= ESC_LIM) || (count >= cap)) ? S_DONE : S_IRR;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        idx_x <= column;
        idx_y <= row;
        axis  <= 1'b0;
      end
      S_MUL: begin
        prod <= mul_p;
        rem  <= '0;
        dcnt <= '0;
      end
      S_DIV: begin
        // shift the dividend out at the top, the quotient bit in at the bottom
        prod <= {prod[PROD_W-2:0], ~borrow};
        rem  <= borrow ? rem_shift[DIM_W-1:0] : trial[DIM_W-1:0];
        dcnt <= dcnt + DCNT_W'(1);
      end
      S_MAP: begin
        if (axis) begin
          c_im <= sat_c;
        end else begin
          c_re <= sat_c;
        end
        axis <= 1'b1;
      end
      S_SQR: begin
        prod <= mul_p;
      end
      S_SQI: begin
        acc  <= prod[ACC_W-1:0];
        prod <= mul_p;
      end
      S_DISK: begin
        count <= (sq_sum <= DISK_LIM) ? cap : '0;
        re    <= '0;
        im    <= '0;
      end
      S_IRR: begin
        prod <= mul_p;
      end
      S_IRI: begin
        acc  <= prod[ACC_W-1:0];
        prod <= mul_p;
      end
      S_IIM: begin
        xprod <= (re[Z_W-1] ^ im[Z_W-1]) ? -$signed(prod[ACC_W-1:0])
                                         : $signed(prod[ACC_W-1:0]);
        prod  <= mul_p;
      end
      S_ESC: begin
        // advance only while neither escaped nor at the cap
        if ((sq_sum < ESC_LIM) && (count < cap)) begin
          re    <= re_next;
          im    <= im_next;
          count <= count + COUNT_BITS'(1);
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          iteration_count <= count;
        end
      end
      default: ;
    endcase
  end

  // Output register: hold the word until taken, refill in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### bench/mandelbrot_escape_time_test.sv
typedef struct {
  bit [11:0]   col;
  bit [11:0]   row;
  int unsigned count;
} pixel_job_t;

class escape_count_board;
  localparam bit [63:0] DISK_Q56 = 64'd1 << 52;
  localparam bit [63:0] FOUR_Q56 = 64'd1 << 58;
  localparam bit [63:0] TWO_Q28  = 64'd1 << 29;

  longint      x_lo, x_hi, y_lo, y_hi;
  int unsigned cols, rows, cap;
  pixel_job_t  owed[$];
  int unsigned errors, pixels, capped, escaped_early;

  function new();
    x_lo = -536870912;
    x_hi = 536870912;
    y_lo = -536870912;
    y_hi = 536870912;
    cols = 800;
    rows = 800;
    cap = 100000;
    errors = 0;
    pixels = 0;
    capped = 0;
    escaped_early = 0;
  endfunction

  function void set_register(logic [mbet_pkg::CFG_IDX_W-1:0] idx,
                             logic [mbet_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      mbet_pkg::REG_X_MIN:    x_lo = longint'($signed(data));
      mbet_pkg::REG_X_MAX:    x_hi = longint'($signed(data));
      mbet_pkg::REG_Y_MIN:    y_lo = longint'($signed(data));
      mbet_pkg::REG_Y_MAX:    y_hi = longint'($signed(data));
      mbet_pkg::REG_WIDTH:    cols = 32'(data[12:0]);
      mbet_pkg::REG_HEIGHT:   rows = 32'(data[12:0]);
      mbet_pkg::REG_MAX_ITER: cap = 32'(data[16:0]);
      default: ;
    endcase
  endfunction

  static function bit [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Truncating divide, zero divisor taken as one, then clamp to Q4.28
  static function longint plane_coord(longint lo, longint hi, longint idx, longint div);
    longint r;
    if (div == 0) div = 1;
    r = lo + (idx * (hi - lo)) / div;
    if (r < -64'sh8000_0000) r = -64'sh8000_0000;
    if (r > 64'sh7FFF_FFFF) r = 64'sh7FFF_FFFF;
    return r;
  endfunction

  function int unsigned escape_steps(longint c_re, longint c_im);
    bit [63:0]   ar, ai;
    longint      re, im, sq, xprod;
    int unsigned n;
    bit          gone;
    re = 0;
    im = 0;
    n = 0;
    gone = 1'b0;
    ar = magnitude(c_re);
    ai = magnitude(c_im);
    if (ar * ar + ai * ai <= DISK_Q56) return cap;
    while (n < cap && !gone) begin
      sq = re * re - im * im;
      xprod = re * im;
      re = (sq >>> 28) + c_re;
      im = (xprod >>> 27) + c_im;
      n++;
      ar = magnitude(re);
      ai = magnitude(im);
      if (ar >= TWO_Q28 || ai >= TWO_Q28) gone = 1'b1;
      else if (ar * ar + ai * ai >= FOUR_Q56) gone = 1'b1;
    end
    return n;
  endfunction

  function void note_pixel(bit [11:0] col, bit [11:0] row);
    pixel_job_t p;
    p.col = col;
    p.row = row;
    p.count = escape_steps(plane_coord(x_lo, x_hi, longint'(col), longint'(cols)),
                           plane_coord(y_lo, y_hi, longint'(row), longint'(rows)));
    pixels++;
    if (p.count == cap) capped++;
    else escaped_early++;
    owed.push_back(p);
  endfunction

  task report(string what);
    errors++;
    $display("ERROR @%0t: %s", $time, what);
  endtask

  task check_count(logic [16:0] got);
    pixel_job_t p;
    if (owed.size() == 0) begin
      report($sformatf("count %0d arrived with no pixel outstanding", got));
      return;
    end
    p = owed.pop_front();
    if (got !== 17'(p.count))
      report($sformatf("pixel (%0d,%0d): count %0d, predicted %0d",
                       p.col, p.row, got, p.count));
  endtask
endclass

module mandelbrot_escape_time_test;
  import mbet_pkg::*;

  localparam int          ONE_Q         = 1 << 28;   // 1.0 in Q4.28
  // Slowest correct word: a full 100000-step pixel plus the mapping dividers,
  // taken about four times over.
  localparam int unsigned STALL_LIMIT   = 1_600_000;
  localparam int unsigned SETTLE_CYCLES = 200;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic [11:0]           column    = '0;
  logic [11:0]           row       = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_ready;
  logic                  out_valid;
  logic [16:0]           iteration_count;

  escape_count_board board;
  bit                source_steady = 1'b1;
  bit                sink_steady   = 1'b1;
  int unsigned       sink_hold     = 0;
  int unsigned       quiet_cycles  = 0;
  int unsigned       views_loaded  = 0;

  mandelbrot_escape_time uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .column          (column),
    .row             (row),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .iteration_count (iteration_count),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mostly no pause, sometimes a short one, now and then a long one
  function automatic int unsigned pause_len(bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: hold ready low for a random stretch after each ready cycle
  always @(posedge clk) begin
    if (sink_hold != 0) begin
      out_ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else begin
      out_ready <= 1'b1;
      sink_hold <= pause_len(sink_steady);
    end
  end

  // Check every result word against the oldest outstanding pixel
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_count(iteration_count);
  end

  // Give up if neither side moves a word for far too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("ERROR: nothing accepted for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one pixel and hold it until taken. Valid is only dropped when a gap
  // is wanted, so back-to-back words keep it high across the edge.
  task automatic send_pixel(input logic [11:0] col, input logic [11:0] rw);
    int unsigned gap;
    gap = pause_len(source_steady);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    column <= col;
    row <= rw;
    do @(posedge clk); while (!in_ready);
    board.note_pixel(col, rw);
  endtask

  // Drop the request and wait until every pixel has been answered; every pixel
  // yields exactly one word, so an empty queue means the block is idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
  endtask

  task automatic put_register(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    board.set_register(idx, data);
    @(posedge clk);
  endtask

  task automatic load_view(input logic [31:0] xl, xh, yl, yh, w, h, lim);
    put_register(REG_X_MIN, xl);
    put_register(REG_X_MAX, xh);
    put_register(REG_Y_MIN, yl);
    put_register(REG_Y_MAX, yh);
    put_register(REG_WIDTH, w);
    put_register(REG_HEIGHT, h);
    put_register(REG_MAX_ITER, lim);
    cfg_write <= 1'b0;
    views_loaded++;
  endtask

  initial begin
    logic [31:0] xl, xh, yl, yh, w, h, lim, tmp;
    logic [11:0] col, rw;
    board = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset view: -2..2 square, 800x800, cap 100000.
    send_pixel(12'd400, 12'd400);    // origin, inside the small disk
    send_pixel(12'd0, 12'd0);        // corner, gone after one step
    send_pixel(12'd799, 12'd799);
    send_pixel(12'd4095, 12'd4095);  // far outside the image, clamps to Q4.28 top
    send_pixel(12'd200, 12'd400);    // c = -1, cycles forever: runs the full cap

    // Cap of zero: small-disk and outer points both answer zero
    settle();
    load_view(-2 * ONE_Q, 2 * ONE_Q, -2 * ONE_Q, 2 * ONE_Q, 800, 800, 0);
    send_pixel(12'd400, 12'd400);
    send_pixel(12'd0, 12'd0);

    // Widest region, zero width hidden under junk high bits, all-ones cap
    settle();
    load_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'hABCD_0000, 1, 32'hFFFF_FFFF);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd1, 12'd1);

    // Reversed real axis on the largest image; probe the small-disk edge
    settle();
    load_view(2 * ONE_Q, -2 * ONE_Q, -ONE_Q, ONE_Q, 4096, 4096, 100);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd2048, 12'd2048);  // c = 0
    send_pixel(12'd1792, 12'd2048);  // c = 0.25, exactly on the disk edge
    send_pixel(12'd1791, 12'd2048);  // just outside it, slow escape
    send_pixel(12'd2048, 12'd3072);  // c = 0.5i, bounded
    send_pixel(12'd4095, 12'd4095);

    // Random views, mostly around the set, small caps to keep the run short
    for (int phase = 0; phase < 5; phase++) begin
      settle();
      if ($urandom_range(0, 4) == 0) begin
        xl = $urandom();
        xh = $urandom();
        yl = $urandom();
        yh = $urandom();
      end else begin
        xl = -5 * (ONE_Q / 2) + $urandom_range(0, 3 * ONE_Q);
        xh = xl + $urandom_range(ONE_Q / 8, 3 * ONE_Q);
        yl = -3 * (ONE_Q / 2) + $urandom_range(0, 2 * ONE_Q);
        yh = yl + $urandom_range(ONE_Q / 8, 3 * ONE_Q);
        if ($urandom_range(0, 5) == 0) begin
          tmp = xl;
          xl = xh;
          xh = tmp;
        end
      end
      case ($urandom_range(0, 5))
        0:       w = 0;
        1:       w = 4096;
        default: w = $urandom_range(1, 4096);
      endcase
      case ($urandom_range(0, 5))
        0:       h = 0;
        1:       h = 4096;
        default: h = $urandom_range(1, 4096);
      endcase
      lim = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 60);
      // First random phase runs flat out; later ones idle at random
      source_steady = (phase == 0) || ($urandom_range(0, 3) == 0);
      sink_steady = (phase == 0) || ($urandom_range(0, 3) == 0);
      load_view(xl, xh, yl, yh, w, h, lim);
      repeat (20) begin
        // Mostly pixels inside the image, some anywhere in the index range
        if (w != 0 && $urandom_range(0, 99) < 85) col = 12'($urandom_range(0, w - 1));
        else col = 12'($urandom_range(0, 4095));
        if (h != 0 && $urandom_range(0, 99) < 85) rw = 12'($urandom_range(0, h - 1));
        else rw = 12'($urandom_range(0, 4095));
        send_pixel(col, rw);
      end
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d pixels over %0d views: %0d held to the cap, %0d escaped before it",
             board.pixels, views_loaded + 1, board.capped, board.escaped_early);
    if (board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

### mandelbrot_escape_time.f
src/mbet_pkg.sv
src/mandelbrot_escape_time.sv
bench/mandelbrot_escape_time_test.sv
